// File: rtl/jsu_pkg.sv
// Shared types, codes and the UTF-8 encoder for the JSON string unescaper.
// Used by jsu_front, jsu_queue, jsu_back and the top level.
package jsu_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 4;

   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_EMPTY_ESC  = 3'd1;
   localparam logic [2:0] ST_BAD_ESC    = 3'd2;
   localparam logic [2:0] ST_FOUR_HEX   = 3'd3;
   localparam logic [2:0] ST_BAD_HEX    = 3'd4;
   localparam logic [2:0] ST_SIX_EXP    = 3'd5;
   localparam logic [2:0] ST_NO_SECOND  = 3'd6;

   // bytes[7:0] goes out first
   typedef struct packed {
      logic [31:0] bytes;
      logic [2:0]  count;
   } jsu_utf8_type;

   typedef struct packed {
      logic [31:0] bytes;
      logic [2:0]  count;
      logic        close;
      logic [2:0]  status;
   } jsu_job_type;

   function automatic jsu_utf8_type utf8_encode(input logic [20:0] cp);
      jsu_utf8_type r;
      r = '0;
      if (cp <= 21'h7F) begin
         r.bytes[7:0] = {1'b0, cp[6:0]};
         r.count      = 3'd1;
      end else if (cp <= 21'h7FF) begin
         r.bytes[7:0]  = {3'b110, cp[10:6]};
         r.bytes[15:8] = {2'b10, cp[5:0]};
         r.count       = 3'd2;
      end else if (cp <= 21'hFFFF) begin
         r.bytes[7:0]   = {4'b1110, cp[15:12]};
         r.bytes[15:8]  = {2'b10, cp[11:6]};
         r.bytes[23:16] = {2'b10, cp[5:0]};
         r.count        = 3'd3;
      end else if (cp <= 21'h10FFFF) begin
         r.bytes[7:0]   = {5'b11110, cp[20:18]};
         r.bytes[15:8]  = {2'b10, cp[17:12]};
         r.bytes[23:16] = {2'b10, cp[11:6]};
         r.bytes[31:24] = {2'b10, cp[5:0]};
         r.count        = 3'd4;
      end
      return r;
   endfunction

endpackage

// File: rtl/jsu_front.sv
// Front end: accepts input words, runs the escape decoder and builds one job
// per word that causes results. Depends on jsu_pkg.
module jsu_front
   import jsu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        accept,
   input  logic [7:0]  in_byte,
   input  logic        carries_char,
   input  logic        token_end,
   output logic        job_valid,
   output jsu_job_type job
);

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_ESC  = 2'd1;
   localparam logic [1:0] PH_HEX  = 2'd2;
   localparam logic [1:0] PH_TAIL = 2'd3;

   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_BSL   = 8'h5C;
   localparam logic [7:0] CH_B     = 8'h62;
   localparam logic [7:0] CH_F     = 8'h66;
   localparam logic [7:0] CH_N     = 8'h6E;
   localparam logic [7:0] CH_R     = 8'h72;
   localparam logic [7:0] CH_T     = 8'h74;
   localparam logic [7:0] CH_U     = 8'h75;

   logic [1:0]  phase_ff, phase_in;
   logic [2:0]  pos_ff, pos_in;
   logic [15:0] acc_ff, acc_in;
   logic [9:0]  hs_ff, hs_in;
   logic        pbad_ff, pbad_in;
   logic        hbad_ff, hbad_in;
   logic [2:0]  err_ff, err_in;
   logic        quote_ff, quote_in;

   logic [3:0]   hex_val;
   logic         hex_ok;
   logic [15:0]  acc_hex;
   logic         hbad_hex;
   logic         active;
   jsu_utf8_type enc;
   jsu_job_type  job_c;

   always_comb begin
      hex_ok  = 1'b1;
      hex_val = 4'd0;
      if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
         hex_val = in_byte[3:0];
      end else if ((in_byte >= 8'h61 && in_byte <= 8'h66) ||
                   (in_byte >= 8'h41 && in_byte <= 8'h46)) begin
         hex_val = in_byte[3:0] + 4'd9;
      end else begin
         hex_ok = 1'b0;
      end
      acc_hex  = hex_ok ? {acc_ff[11:0], hex_val} : acc_ff;
      hbad_hex = hbad_ff | ~hex_ok;
   end

   always_comb begin
      phase_in = phase_ff;
      pos_in   = pos_ff;
      acc_in   = acc_ff;
      hs_in    = hs_ff;
      pbad_in  = pbad_ff;
      hbad_in  = hbad_ff;
      err_in   = err_ff;
      quote_in = quote_ff;
      job_c    = '0;
      enc      = '0;
      active   = (err_ff == ST_OK) && !quote_ff;

      if (carries_char && active) begin
         unique case (phase_ff)
            PH_ESC: begin
               phase_in = PH_IDLE;
               job_c.count = 3'd1;
               case (in_byte)
                  CH_QUOTE: job_c.bytes[7:0] = CH_QUOTE;
                  CH_SLASH: job_c.bytes[7:0] = CH_SLASH;
                  CH_BSL:   job_c.bytes[7:0] = CH_BSL;
                  CH_B:     job_c.bytes[7:0] = 8'h08;
                  CH_F:     job_c.bytes[7:0] = 8'h0C;
                  CH_N:     job_c.bytes[7:0] = 8'h0A;
                  CH_R:     job_c.bytes[7:0] = 8'h0D;
                  CH_T:     job_c.bytes[7:0] = 8'h09;
                  CH_U: begin
                     job_c.count = 3'd0;
                     phase_in    = PH_HEX;
                     pos_in      = 3'd0;
                     acc_in      = 16'd0;
                     hbad_in     = 1'b0;
                  end
                  default: begin
                     job_c.count = 3'd0;
                     err_in      = ST_BAD_ESC;
                  end
               endcase
            end
            PH_HEX: begin
               acc_in  = acc_hex;
               hbad_in = hbad_hex;
               pos_in  = pos_ff + 3'd1;
               if (pos_ff == 3'd3) begin
                  phase_in = PH_IDLE;
                  pos_in   = 3'd0;
                  if (hbad_hex) begin
                     err_in = ST_BAD_HEX;
                  end else if (acc_hex >= 16'hD800 && acc_hex <= 16'hDBFF) begin
                     hs_in    = acc_hex[9:0];
                     phase_in = PH_TAIL;
                     acc_in   = 16'd0;
                     pbad_in  = 1'b0;
                     hbad_in  = 1'b0;
                  end else begin
                     enc         = utf8_encode({5'd0, acc_hex});
                     job_c.bytes = enc.bytes;
                     job_c.count = enc.count;
                  end
               end
            end
            PH_TAIL: begin
               if (pos_ff == 3'd0) begin
                  pbad_in = pbad_ff | (in_byte != CH_BSL);
               end else if (pos_ff == 3'd1) begin
                  pbad_in = pbad_ff | (in_byte != CH_U);
               end else begin
                  acc_in  = acc_hex;
                  hbad_in = hbad_hex;
               end
               pos_in = pos_ff + 3'd1;
               if (pos_ff == 3'd5) begin
                  phase_in = PH_IDLE;
                  pos_in   = 3'd0;
                  if (pbad_in) begin
                     err_in = ST_NO_SECOND;
                  end else if (hbad_in) begin
                     err_in = ST_BAD_HEX;
                  end else begin
                     enc = utf8_encode(21'h10000 + {1'b0, hs_ff, acc_in[9:0]});
                     job_c.bytes = enc.bytes;
                     job_c.count = enc.count;
                  end
               end
            end
            default: begin
               if (in_byte == CH_QUOTE) begin
                  quote_in = 1'b1;
               end else if (in_byte == CH_BSL) begin
                  phase_in = PH_ESC;
               end else begin
                  job_c.bytes[7:0] = in_byte;
                  job_c.count      = 3'd1;
               end
            end
         endcase
      end

      if (token_end) begin
         if (err_in == ST_OK && !quote_in) begin
            unique case (phase_in)
               PH_ESC:  err_in = ST_EMPTY_ESC;
               PH_HEX:  err_in = ST_FOUR_HEX;
               PH_TAIL: err_in = ST_SIX_EXP;
               default: err_in = ST_OK;
            endcase
         end
         job_c.close  = 1'b1;
         job_c.status = err_in;
         phase_in = PH_IDLE;
         pos_in   = 3'd0;
         acc_in   = 16'd0;
         hs_in    = 10'd0;
         pbad_in  = 1'b0;
         hbad_in  = 1'b0;
         err_in   = ST_OK;
         quote_in = 1'b0;
      end
   end

   assign job       = job_c;
   assign job_valid = accept && (job_c.close || job_c.count != 3'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         pos_ff   <= 3'd0;
         acc_ff   <= 16'd0;
         hs_ff    <= 10'd0;
         pbad_ff  <= 1'b0;
         hbad_ff  <= 1'b0;
         err_ff   <= ST_OK;
         quote_ff <= 1'b0;
      end else if (accept) begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         acc_ff   <= acc_in;
         hs_ff    <= hs_in;
         pbad_ff  <= pbad_in;
         hbad_ff  <= hbad_in;
         err_ff   <= err_in;
         quote_ff <= quote_in;
      end
   end

endmodule

// File: rtl/jsu_queue.sv
// Job queue between the decoder front end and the result back end.
// Depends on jsu_pkg for the job type.
module jsu_queue
   import jsu_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  jsu_job_type push_job,
   output logic        full,
   input  logic        pop,
   output logic        pop_valid,
   output jsu_job_type pop_job
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   jsu_job_type        mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               do_push, do_pop;

   assign full      = (cnt_ff == CNT_W'(QUEUE_DEPTH));
   assign pop_valid = (cnt_ff != '0);
   assign pop_job   = mem_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// File: rtl/jsu_back.sv
// Back end: takes jobs from the queue and sends their result words one per
// cycle via an output register unless rsp_tready stalls. Depends on jsu_pkg.
module jsu_back
   import jsu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        job_valid,
   input  jsu_job_type job,
   output logic        job_pop,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,
   output logic [4:0]  rsp_tuser,
   output logic        rsp_tlast
);

   jsu_job_type cur_ff;
   logic        cur_valid_ff;
   logic [2:0]  pos_ff;
   logic        out_valid_ff;
   logic [7:0]  out_data_ff, out_data_in;
   logic [4:0]  out_user_ff, out_user_in;
   logic        out_last_ff, out_last_in;

   logic [2:0]  total;
   logic        is_last;
   logic        emit;

   assign total   = cur_ff.count + {2'b00, cur_ff.close};
   assign is_last = (pos_ff == total - 3'd1);
   assign emit    = cur_valid_ff && (!out_valid_ff || rsp_tready);
   assign job_pop = job_valid && (!cur_valid_ff || (emit && is_last));

   always_comb begin
      out_last_in = is_last;
      if (pos_ff < cur_ff.count) begin
         out_data_in = cur_ff.bytes[pos_ff[1:0]*8 +: 8];
         out_user_in = {ST_OK, 1'b0, 1'b1};
      end else begin
         out_data_in = 8'd0;
         out_user_in = {cur_ff.status, 1'b1, 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         pos_ff       <= 3'd0;
      end else begin
         if (job_pop) begin
            cur_valid_ff <= 1'b1;
            pos_ff       <= 3'd0;
         end else if (emit) begin
            if (is_last) begin
               cur_valid_ff <= 1'b0;
            end else begin
               pos_ff <= pos_ff + 3'd1;
            end
         end
         if (emit) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (job_pop) begin
         cur_ff <= job;
      end
      if (emit) begin
         out_data_ff <= out_data_in;
         out_user_ff <= out_user_in;
         out_last_ff <= out_last_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_user_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

// File: rtl/json_string_unescape_utf8.sv
// JSON string unescaper with UTF-8 output: one content byte of a string token
// per input word, decoded results one per output word. Input words are taken
// one per cycle while the job queue (QUEUE_DEPTH entries) has room; each word
// that causes results becomes one queue job. The back end sends one result
// word per cycle unless rsp_tready stalls it, so a word causing k results (up
// to four UTF-8 bytes plus the closing word) holds the back end until all k
// are sent, and the sustained rate is one input byte per cycle for ordinary
// text without stalls. Results pass the queue and the back end's job and output
// registers. Depends on jsu_pkg, jsu_front, jsu_queue, jsu_back.
module json_string_unescape_utf8
   import jsu_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // in_byte
   input  logic       req_tuser,   // carries_char
   input  logic       req_tlast,   // token_end
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // out_byte
   output logic [4:0] rsp_tuser,   // byte_valid, token_done, status[2:0]
   output logic       rsp_tlast    // run_last
);

   logic        accept;
   logic        q_full;
   logic        push;
   jsu_job_type push_job;
   logic        pop;
   logic        pop_valid;
   jsu_job_type pop_job;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;

   jsu_front u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .in_byte      (req_tdata),
      .carries_char (req_tuser),
      .token_end    (req_tlast),
      .job_valid    (push),
      .job          (push_job)
   );

   jsu_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (push_job),
      .full      (q_full),
      .pop       (pop),
      .pop_valid (pop_valid),
      .pop_job   (pop_job)
   );

   jsu_back u_back (
      .clock      (clock),
      .reset      (reset),
      .job_valid  (pop_valid),
      .job        (pop_job),
      .job_pop    (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
